### hdl/dacs_pkg.sv
// package: types, codes and constants of the decimal accumulator machine
package dacs_pkg;
   localparam int MemWords = 100;
   localparam int AddrBits = 7;
   localparam int WordBits = 15;
   localparam logic signed [WordBits-1:0] WordMax = 15'sd9999;
   localparam logic signed [WordBits-1:0] WordMin = -15'sd9999;
   localparam logic [AddrBits-1:0] PcEnd = 7'd100;

   typedef enum logic [2:0] {
      ST_RUN = 3'd0, ST_HALT = 3'd1, ST_END = 3'd2,
      ST_OVF = 3'd3, ST_DIV0 = 3'd4, ST_BADOP = 3'd5
   } status_type;

   typedef enum logic [5:0] {
      OP_READ = 6'd10, OP_WRITE = 6'd11, OP_LOAD = 6'd20, OP_STORE = 6'd21,
      OP_ADD = 6'd30, OP_SUB = 6'd31, OP_DIV = 6'd32, OP_MUL = 6'd33,
      OP_BR = 6'd40, OP_BRNEG = 6'd41, OP_BRZERO = 6'd42, OP_HALT = 6'd43
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_FETCH_WAIT, S_DECODE, S_OPER, S_OPER_WAIT,
      S_EXEC, S_DIV_RUN, S_DIV_DONE, S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch request
      logic load_write;  // perform load item
      logic rd_pc;       // memory read at pc
      logic split;       // capture opcode / address of fetched word
      logic rd_oper;     // memory read at operand address
      logic grab_oper;   // latch operand
      logic exec;        // execute op other than a divide by a nonzero operand
      logic div_start;
      logic div_step;
      logic div_finish;
      logic rsp_set;
      logic rsp_clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic running;
      logic is_div;
      logic div_last;
      logic rsp_busy;
   } stat_type;
endpackage

### hdl/dacs_ctrl.sv
// controller state machine sequencing fetch, operand read, execute and response
module dacs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  dacs_pkg::stat_type stat,
   output dacs_pkg::cmd_type  cmd
);
   import dacs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !stat.rsp_busy) state_in = S_FETCH;
         end
         S_FETCH: begin
            if (stat.is_load || !stat.running) state_in = S_RESP;
            else state_in = S_FETCH_WAIT;
         end
         S_FETCH_WAIT: state_in = S_DECODE;
         S_DECODE: state_in = S_OPER;
         S_OPER: state_in = S_OPER_WAIT;
         S_OPER_WAIT: state_in = S_EXEC;
         S_EXEC: begin
            if (stat.is_div) state_in = S_DIV_RUN;
            else state_in = S_RESP;
         end
         S_DIV_RUN: begin
            if (stat.div_last) state_in = S_DIV_DONE;
         end
         S_DIV_DONE: state_in = S_RESP;
         S_RESP: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !stat.rsp_busy;
            cmd.capture = req_tvalid && !stat.rsp_busy;
         end
         S_FETCH: begin
            cmd.load_write = stat.is_load;
            cmd.rd_pc = !stat.is_load;
         end
         S_FETCH_WAIT: ;
         S_DECODE: cmd.split = 1'b1;
         S_OPER: cmd.rd_oper = 1'b1;
         S_OPER_WAIT: cmd.grab_oper = 1'b1;
         S_EXEC: begin
            cmd.exec = !stat.is_div;
            cmd.div_start = stat.is_div;
         end
         S_DIV_RUN: cmd.div_step = 1'b1;
         S_DIV_DONE: cmd.div_finish = 1'b1;
         S_RESP: cmd.rsp_set = !stat.rsp_busy;
         default: ;
      endcase
   end
endmodule

### hdl/dacs_datapath.sv
// datapath: word memory, accumulator, pc, status, serial divider, result register
module dacs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dacs_pkg::cmd_type               cmd,
   output dacs_pkg::stat_type              stat,
   input  logic [39:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata
);
   import dacs_pkg::*;

   logic signed [WordBits-1:0] mem [MemWords];
   logic [MemWords-1:0]        valid_ff;
   logic signed [WordBits-1:0] rdata_ff;

   logic                        kind_ff;
   logic [AddrBits-1:0]         laddr_ff;
   logic signed [WordBits-1:0]  lword_ff, rval_ff;

   logic signed [WordBits-1:0] acc_ff, acc_in;
   logic [AddrBits-1:0]        pc_ff, pc_in;
   status_type                 st_ff, st_in;
   logic [6:0]                 op_ff;
   logic [AddrBits-1:0]        addr_ff;
   logic                       neg_ff;
   logic signed [WordBits-1:0] oper_ff;

   logic                       emit_ff;
   logic signed [WordBits-1:0] ev_ff;
   logic [AddrBits-1:0]        ea_ff;

   // serial divider on magnitudes
   logic [13:0] quo_ff, rem_ff, dvs_ff;
   logic [3:0]  dcnt_ff;
   logic        qneg_ff;

   logic        wr_en;
   logic [AddrBits-1:0] wr_addr, rd_addr;
   logic signed [WordBits-1:0] wr_data;
   logic rd_en;

   // opcode / address split of fetched word: op = w/100 for w in 0..9999
   logic [13:0] wmag;
   logic [26:0] wprod;
   logic [6:0]  qd;
   logic [13:0] rm;
   logic [6:0]  qfix;
   logic [6:0]  rfix;

   always_comb begin
      wmag = rdata_ff[13:0];
      wprod = wmag * 13'd5243;
      qd = wprod[25:19];
      rm = wmag - 14'(qd * 7'd100);
      qfix = qd;
      rfix = rm[6:0];
      if (rm >= 14'd100) begin
         qfix = qd + 7'd1;
         rfix = 7'(rm - 14'd100);
      end
   end

   logic signed [WordBits:0]   sum;
   logic signed [29:0]         prod;
   logic signed [WordBits-1:0] rsat;
   logic                       ovf;
   logic                       adv_ok;

   assign prod = acc_ff * oper_ff;

   always_comb begin
      acc_in = acc_ff;
      pc_in = pc_ff;
      st_in = st_ff;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = acc_ff;
      sum = '0;
      ovf = 1'b0;
      adv_ok = 1'b0;
      rsat = rval_ff;
      if (rval_ff > WordMax) rsat = WordMax;
      if (rval_ff < WordMin) rsat = WordMin;
      if (cmd.load_write) begin
         wr_addr = laddr_ff;
         wr_data = lword_ff;
         wr_en = (laddr_ff < AddrBits'(MemWords)) &&
                 (lword_ff <= WordMax) && (lword_ff >= WordMin);
      end
      if (cmd.exec) begin
         if (neg_ff) begin
            st_in = ST_BADOP;
         end else begin
            case (op_ff)
               7'(OP_READ): begin
                  wr_en = 1'b1;
                  wr_data = rsat;
                  adv_ok = 1'b1;
               end
               7'(OP_WRITE): adv_ok = 1'b1;
               7'(OP_LOAD): begin
                  acc_in = oper_ff;
                  adv_ok = 1'b1;
               end
               7'(OP_STORE): begin
                  wr_en = 1'b1;
                  adv_ok = 1'b1;
               end
               7'(OP_ADD), 7'(OP_SUB): begin
                  if (op_ff == 7'(OP_ADD)) sum = acc_ff + oper_ff;
                  else sum = acc_ff - oper_ff;
                  ovf = (sum > 16'sd9999) || (sum < -16'sd9999);
                  if (ovf) st_in = ST_OVF;
                  else begin
                     acc_in = sum[WordBits-1:0];
                     adv_ok = 1'b1;
                  end
               end
               7'(OP_MUL): begin
                  ovf = (prod > 30'sd9999) || (prod < -30'sd9999);
                  if (ovf) st_in = ST_OVF;
                  else begin
                     acc_in = prod[WordBits-1:0];
                     adv_ok = 1'b1;
                  end
               end
               // divide reaches here only with a zero divisor
               7'(OP_DIV): st_in = ST_DIV0;
               7'(OP_BR): pc_in = addr_ff;
               7'(OP_BRNEG): begin
                  if (acc_ff < 0) pc_in = addr_ff;
                  else adv_ok = 1'b1;
               end
               7'(OP_BRZERO): begin
                  if (acc_ff == 0) pc_in = addr_ff;
                  else adv_ok = 1'b1;
               end
               7'(OP_HALT): st_in = ST_HALT;
               default: st_in = ST_BADOP;
            endcase
         end
      end
      if (cmd.div_finish) begin
         acc_in = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
         adv_ok = 1'b1;
      end
      if (adv_ok) begin
         pc_in = pc_ff + 7'd1;
         if (pc_in >= PcEnd) begin
            pc_in = PcEnd;
            st_in = ST_END;
         end
      end
   end

   assign rd_en = cmd.rd_pc || cmd.rd_oper;
   assign rd_addr = cmd.rd_pc ? pc_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   // unwritten words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pc_ff <= '0;
         st_ff <= ST_RUN;
         rsp_tvalid <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         pc_ff <= pc_in;
         st_ff <= st_in;
         if (cmd.rsp_set) rsp_tvalid <= 1'b1;
         else if (rsp_tready) rsp_tvalid <= 1'b0;
         if (cmd.div_start) dcnt_ff <= 4'd13;
         else if (cmd.div_step && dcnt_ff != 0) dcnt_ff <= dcnt_ff - 4'd1;
      end
   end

   logic [15:0] trial;
   logic [14:0] rsh;
   assign rsh = {rem_ff, quo_ff[13]};
   assign trial = {1'b0, rsh} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tdata[0];
         laddr_ff <= req_tdata[7:1];
         lword_ff <= req_tdata[22:8];
         rval_ff <= req_tdata[37:23];
         emit_ff <= 1'b0;
         ev_ff <= '0;
         ea_ff <= '0;
      end
      if (cmd.split) begin
         neg_ff <= rdata_ff[WordBits-1];
         op_ff <= qfix;
         addr_ff <= rfix;
      end
      if (cmd.grab_oper) oper_ff <= rdata_ff;
      if (cmd.exec && !neg_ff && op_ff == 7'(OP_WRITE)) begin
         emit_ff <= 1'b1;
         ev_ff <= oper_ff;
         ea_ff <= addr_ff;
      end
      if (cmd.div_start) begin
         quo_ff <= acc_ff[WordBits-1] ? 14'(-acc_ff) : acc_ff[13:0];
         dvs_ff <= oper_ff[WordBits-1] ? 14'(-oper_ff) : oper_ff[13:0];
         rem_ff <= '0;
         qneg_ff <= acc_ff[WordBits-1] ^ oper_ff[WordBits-1];
      end
      if (cmd.div_step) begin
         if (!trial[15]) begin
            rem_ff <= trial[13:0];
            quo_ff <= {quo_ff[12:0], 1'b1};
         end else begin
            rem_ff <= rsh[13:0];
            quo_ff <= {quo_ff[12:0], 1'b0};
         end
      end
   end

   always_comb begin
      stat.is_load = !kind_ff;
      stat.running = (st_ff == ST_RUN) && (pc_ff < AddrBits'(MemWords));
      stat.is_div = !neg_ff && op_ff == 7'(OP_DIV) && oper_ff != 0;
      stat.div_last = dcnt_ff == 4'd0;
      stat.rsp_busy = rsp_tvalid && !rsp_tready;
   end

   assign rsp_tdata = {pc_ff, acc_ff, ea_ff, ev_ff, emit_ff, 3'(st_ff)};
endmodule

### hdl/decimal_accumulator_cpu_step_top.sv
// top level of the decimal accumulator machine
// Each transfer is a memory load or one executed instruction and returns one result.
// A load is written from the fetch state; an instruction goes through fetch, operand
// read and execute in the word memory, and a divide adds the bit-serial quotient
// loop and its final step. No new request is taken until the result of the previous
// one has been transferred out of the output register.
module decimal_accumulator_cpu_step_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type, load_address, load_word, read_value, zero fill
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // run_status, emit_valid, emit_value, emit_address, acc_value, next_pc
   output logic [47:0] rsp_tdata
);
   import dacs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dacs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .cmd(cmd)
   );

   dacs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule

### tb/decimal_accumulator_cpu_step_checker.sv
// checker: predicts and compares every result of the decimal accumulator machine
`timescale 1ns / 100ps
module decimal_accumulator_cpu_step_checker
   import dacs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   typedef struct {
      status_type           status;
      logic                 emit;
      logic signed [14:0]   emit_value;
      logic [6:0]           emit_addr;
      logic signed [14:0]   acc;
      logic [6:0]           pc;
   } machine_result_t;

   int              word_mem [MemWords];
   int              acc_reg;
   int              pc_reg;
   status_type      status_reg;
   machine_result_t result_queue [$];

   function automatic void bump_pc();
      pc_reg = pc_reg + 1;
      if (pc_reg >= MemWords) begin
         pc_reg = MemWords;
         status_reg = ST_END;
      end
   endfunction

   function automatic bit word_ok(input int v);
      return v >= WordMin && v <= WordMax;
   endfunction

   function automatic machine_result_t run_item(input logic [39:0] d);
      machine_result_t r;
      int a, w, rv, ir, op, ad, addr, m, v;
      r.emit = 0;
      r.emit_value = 0;
      r.emit_addr = 0;
      a = d[7:1];
      w = $signed(d[22:8]);
      rv = $signed(d[37:23]);
      if (!d[0]) begin
         if (a < MemWords && word_ok(w)) word_mem[a] = w;
      end else if (status_reg == ST_RUN && pc_reg < MemWords) begin
         ir = word_mem[pc_reg];
         op = ir / 100;
         ad = ir % 100;
         addr = (ad >= 0 && ad < MemWords) ? ad : 0;
         m = word_mem[addr];
         if (ad < 0) op = -1;
         case (op)
            OP_READ: begin
               v = rv;
               if (v > WordMax) v = WordMax;
               if (v < WordMin) v = WordMin;
               word_mem[addr] = v;
               bump_pc();
            end
            OP_WRITE: begin
               r.emit = 1;
               r.emit_value = m;
               r.emit_addr = addr;
               bump_pc();
            end
            OP_LOAD: begin
               acc_reg = m;
               bump_pc();
            end
            OP_STORE: begin
               word_mem[addr] = acc_reg;
               bump_pc();
            end
            OP_ADD, OP_SUB, OP_MUL: begin
               if (op == OP_ADD) v = acc_reg + m;
               else if (op == OP_SUB) v = acc_reg - m;
               else v = acc_reg * m;
               if (!word_ok(v)) status_reg = ST_OVF;
               else begin
                  acc_reg = v;
                  bump_pc();
               end
            end
            OP_DIV: begin
               if (m == 0) status_reg = ST_DIV0;
               else begin
                  acc_reg = acc_reg / m;
                  bump_pc();
               end
            end
            OP_BR: pc_reg = addr;
            OP_BRNEG: begin
               if (acc_reg < 0) pc_reg = addr;
               else bump_pc();
            end
            OP_BRZERO: begin
               if (acc_reg == 0) pc_reg = addr;
               else bump_pc();
            end
            OP_HALT: status_reg = ST_HALT;
            default: status_reg = ST_BADOP;
         endcase
      end
      r.status = status_reg;
      r.acc = acc_reg;
      r.pc = pc_reg;
      return r;
   endfunction

   always @(posedge clock) begin
      machine_result_t want;
      if (reset) begin
         foreach (word_mem[i]) word_mem[i] = 0;
         acc_reg = 0;
         pc_reg = 0;
         status_reg = ST_RUN;
         result_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) result_queue.push_back(run_item(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[2:0] !== want.status ||
                   rsp_tdata[3] !== want.emit ||
                   rsp_tdata[18:4] !== want.emit_value ||
                   rsp_tdata[25:19] !== want.emit_addr ||
                   rsp_tdata[40:26] !== want.acc ||
                   rsp_tdata[47:41] !== want.pc ||
                   rsp_tdata[47:41] === 'x) begin
                  if (rsp_tdata[2:0] !== want.status)
                     $error("run_status exp %0d got %0d", want.status, rsp_tdata[2:0]);
                  if (rsp_tdata[3] !== want.emit)
                     $error("emit_valid exp %0d got %0d", want.emit, rsp_tdata[3]);
                  if (rsp_tdata[18:4] !== want.emit_value)
                     $error("emit_value exp %0d got %0d", want.emit_value,
                            $signed(rsp_tdata[18:4]));
                  if (rsp_tdata[25:19] !== want.emit_addr)
                     $error("emit_address exp %0d got %0d", want.emit_addr,
                            rsp_tdata[25:19]);
                  if (rsp_tdata[40:26] !== want.acc)
                     $error("acc_value exp %0d got %0d", want.acc,
                            $signed(rsp_tdata[40:26]));
                  if (rsp_tdata[47:41] !== want.pc)
                     $error("next_pc exp %0d got %0d", want.pc, rsp_tdata[47:41]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= result_queue.size();
   end
endmodule

### tb/decimal_accumulator_cpu_step_top_tb.sv
// testbench top: stimulus, handshake idling and verdict for the decimal accumulator machine
`timescale 1ns / 100ps
module decimal_accumulator_cpu_step_top_tb;
   import dacs_pkg::*;

   localparam int QuietLimit = 4000;
   localparam int ItemTarget = 1750;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   int          fail_count;
   int          pending;

   logic [47:0] last_rsp = '0;
   int          rsp_count = 0;
   int          item_count = 0;
   int          quiet = 0;
   int          rsp_stall = 0;
   bit          idling = 1;

   always #5 clock = ~clock;

   decimal_accumulator_cpu_step_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   decimal_accumulator_cpu_step_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idling || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         last_rsp <= rsp_tdata;
         rsp_count <= rsp_count + 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 0;
      end else begin
         rsp_stall <= gap_len();
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one transfer in, then wait for its result
   task automatic send(input bit kind, input logic [6:0] addr, input logic [14:0] word,
                       input logic [14:0] rval);
      int c0;
      c0 = rsp_count;
      repeat (gap_len()) @(posedge clock);
      req_tdata <= {2'b00, rval, word, addr, kind};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 0;
      while (rsp_count == c0) @(posedge clock);
      item_count++;
      if (item_count % 250 == 0) idling = !idling;
   endtask

   task automatic load(input int addr, input int word);
      send(0, addr[6:0], word[14:0], 15'($urandom));
   endtask

   task automatic step(input int rval);
      send(1, 7'($urandom), 15'($urandom), rval[14:0]);
   endtask

   // place one instruction at the current pc, optionally with its operand, and run it
   task automatic run_op(input opcode_type op, input int addr, input bit with_oper,
                         input int oper, input int rval);
      int pc;
      pc = last_rsp[47:41];
      if (with_oper) load(addr, oper);
      load(pc, int'(op) * 100 + addr);
      step(rval);
   endtask

   task automatic random_op(input int forced);
      int pc, acc, addr, m, lim, k;
      opcode_type op;
      opcode_type ops [11];
      ops = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV, OP_MUL,
              OP_BR, OP_BRNEG, OP_BRZERO};
      pc = last_rsp[47:41];
      acc = $signed(last_rsp[40:26]);
      if ($urandom_range(0, 5) == 0)
         load($urandom_range(0, 127), $signed(15'($urandom)));
      k = (forced >= 0) ? forced : $urandom_range(0, 10);
      op = (pc == MemWords - 1) ? OP_BR : ops[k];
      do addr = $urandom_range(0, MemWords - 1); while (addr == pc);
      case (op)
         OP_ADD: m = pick((acc < 0) ? WordMin - acc : WordMin,
                          (acc > 0) ? WordMax - acc : WordMax);
         OP_SUB: m = pick((acc > 0) ? acc - WordMax : WordMin,
                          (acc < 0) ? acc + WordMax : WordMax);
         OP_MUL: begin
            lim = (acc == 0) ? WordMax : WordMax / ((acc < 0) ? -acc : acc);
            m = pick(-lim, lim);
         end
         OP_DIV: begin
            do m = ($urandom_range(0, 1)) ? pick(-20, 20) : pick(WordMin, WordMax);
            while (m == 0);
         end
         default: m = ($urandom_range(0, 3) == 0) ? 0 : pick(WordMin, WordMax);
      endcase
      run_op(op, addr, 1, m, $urandom);
   endtask

   initial begin
      int k, pc;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // field extremes, ignored loads, read saturation
      load(127, 100);
      load(100, 0);
      load(5, -16384);
      load(6, 16383);
      load(99, WordMax);
      load(98, WordMin);
      run_op(OP_READ, 7, 0, 0, 16383);
      run_op(OP_READ, 8, 0, 0, -16384);
      run_op(OP_WRITE, 7, 0, 0, 0);
      run_op(OP_LOAD, 99, 0, 0, 0);
      for (k = 0; k < 11; k++) random_op(k);

      while (item_count < ItemTarget) random_op(-1);

      // one sticky stop at the end, chosen at random
      pc = last_rsp[47:41];
      case ($urandom_range(0, 4))
         0: run_op(OP_HALT, 0, 0, 0, 0);
         1: begin
            run_op(OP_LOAD, (pc + 50) % MemWords, 1, WordMax, 0);
            run_op(OP_ADD, (pc + 51) % MemWords, 1, WordMax, 0);
         end
         2: run_op(OP_DIV, (pc + 50) % MemWords, 1, 0, 0);
         3: begin
            load(pc, ($urandom_range(0, 1)) ? -pick(1, WordMax) : 5000 + pick(0, 99));
            step(0);
         end
         default: begin
            run_op(OP_BR, MemWords - 1, 0, 0, 0);
            run_op(OP_LOAD, 3, 0, 0, 0);
         end
      endcase
      for (k = 0; k < 8; k++) begin
         load($urandom_range(0, MemWords - 1), pick(WordMin, WordMax));
         step($urandom);
      end

      k = 0;
      while (pending != 0 && k < 1000) begin
         @(posedge clock);
         k++;
      end
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
